FILE: design/free_list_segment_allocator_defines.svh
// Assertion helpers used by the allocator top module.
`ifndef FREE_LIST_SEGMENT_ALLOCATOR_DEFINES_SVH
`define FREE_LIST_SEGMENT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FLSA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define FLSA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/flsa_pkg.sv
package flsa_pkg;

  localparam int START_W = 16;
  localparam int LEN_W   = 17;

  // Table entry: one segment.
  typedef struct packed {
    logic [LEN_W-1:0]   len;
    logic [START_W-1:0] start;
  } entry_t;

  // Cell operations, broadcast along a chain.
  localparam logic [2:0] OP_HOLD = 3'd0;
  localparam logic [2:0] OP_ROT  = 3'd1;
  localparam logic [2:0] OP_WR   = 3'd2;
  localparam logic [2:0] OP_INS  = 3'd3;
  localparam logic [2:0] OP_DEL  = 3'd4;

  typedef struct packed {
    logic [2:0] code;
    entry_t     data;
  } op_t;

  // Commands.
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_RSVD  = 2'd3;

  // Placement policies.
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;
  localparam logic [1:0] FIT_RSVD  = 2'd3;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

endpackage

FILE: design/flsa_cell.sv
module flsa_cell #(
  parameter int IW = 6,
  parameter int K  = 0
) (
  input  logic            clk,
  input  flsa_pkg::op_t   op,
  input  logic [IW-1:0]   idx,
  input  flsa_pkg::entry_t left,
  input  flsa_pkg::entry_t right,
  output flsa_pkg::entry_t q
);
  import flsa_pkg::*;

  localparam logic [IW-1:0] MY = IW'(K);

  always_ff @(posedge clk) begin
    unique case (op.code)
      OP_ROT: q <= right;
      OP_WR: begin
        if (MY == idx) q <= op.data;
      end
      OP_INS: begin
        if (MY == idx) q <= op.data;
        else if (MY > idx) q <= left;
      end
      OP_DEL: begin
        if (MY >= idx) q <= right;
      end
      default: q <= q;
    endcase
  end

endmodule

FILE: design/flsa_chain.sv
module flsa_chain #(
  parameter int M  = 64,
  parameter int IW = 6
) (
  input  logic             clk,
  input  flsa_pkg::op_t    op,
  input  logic [IW-1:0]    idx,
  output flsa_pkg::entry_t head
);
  import flsa_pkg::*;

  entry_t cells [M];

  // Ring: cell k sees k-1 on the left and k+1 on the right.
  for (genvar k = 0; k < M; k++) begin : g_cell
    flsa_cell #(.IW(IW), .K(k)) u_cell (
      .clk   (clk),
      .op    (op),
      .idx   (idx),
      .left  (cells[(k + M - 1) % M]),
      .right (cells[(k + 1) % M]),
      .q     (cells[k])
    );
  end

  assign head = cells[0];

endmodule

FILE: design/free_list_segment_allocator.sv
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    s_tdata: cmd, req_bytes, user_addr
// m_*       out  m_tvalid/m_tready    m_tdata: ok, out_addr, usable_bytes
// cfg_*     in   cfg_valid/cfg_ready  cfg_data: fit_mode
//
// Scans: each table sits in a ring of MAX_BLOCKS cells; a scan rotates the
// ring once while the head cell is examined. Allocate scans free then used
// ring and applies; free scans used then free ring and applies (plus a step
// on a two-sided merge); query scans the used ring; an allocate with no fit
// or a free/query of an unknown block ends after one scan; rejects scan none.
// Reset: one cycle after rst loads the whole-pool segment; no transfer then.
// Stalls: a new item is taken while a result waits in the output register;
// the finished result of the next item holds until that register drains.
module free_list_segment_allocator #(
  parameter int POOL_BYTES   = 65536,
  parameter int HEADER_BYTES = 8,
  parameter int MAX_BLOCKS   = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [1:0] cmd, [17:2] req_bytes, [33:18] user_addr, rest zero
  input  logic [flsa_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [0] ok, [16:1] out_addr, [32:17] usable_bytes, rest zero
  output logic [flsa_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_data
);
  import flsa_pkg::*;
  `include "free_list_segment_allocator_defines.svh"

  localparam int M  = MAX_BLOCKS;
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [LEN_W-1:0]   HDR   = LEN_W'(HEADER_BYTES);
  localparam logic [LEN_W-1:0]   HDR1  = LEN_W'(HEADER_BYTES + 1);
  localparam logic [LEN_W-1:0]   ROUND = LEN_W'(HEADER_BYTES + 4);
  localparam logic [START_W-1:0] HDR_S = START_W'(HEADER_BYTES);
  localparam logic [CW-1:0]      FULL  = CW'(MAX_BLOCKS);
  localparam logic [IW-1:0]      LAST  = IW'(MAX_BLOCKS - 1);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_FSCAN  = 3'd2;
  localparam logic [2:0] ST_USCAN  = 3'd3;
  localparam logic [2:0] ST_APPLY  = 3'd4;
  localparam logic [2:0] ST_APPLY2 = 3'd5;
  localparam logic [2:0] ST_RESP   = 3'd6;

  logic [2:0]          state;
  logic [1:0]          fit_mode;
  logic [CW-1:0]       free_count, used_count;
  logic [IW-1:0]       step;
  // per-command working registers
  logic [1:0]          cmd;
  logic [LEN_W-1:0]    need;
  logic [START_W-1:0]  tgt;
  logic                found, stop, have_next;
  logic [IW-1:0]       hit_idx, prev_idx;
  logic [CW-1:0]       pos;
  logic [START_W-1:0]  sel_s;
  logic [LEN_W-1:0]    sel_len, best;
  entry_t              prev_e, next_e;
  logic                res_ok;
  logic [START_W-1:0]  res_addr, res_usable;

  op_t                 fop, uop;
  logic [IW-1:0]       fidx, uidx;
  entry_t              fhead, uhead;

  flsa_chain #(.M(M), .IW(IW)) u_free (
    .clk(clk), .op(fop), .idx(fidx), .head(fhead)
  );
  flsa_chain #(.M(M), .IW(IW)) u_used (
    .clk(clk), .op(uop), .idx(uidx), .head(uhead)
  );

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  logic s_acc;
  assign s_acc = s_tvalid && s_tready;

  // Scan-side terms at the head cell
  logic             fvalid, uvalid, fits, last;
  logic [LEN_W-1:0] rest;
  assign fvalid = CW'(step) < free_count;
  assign uvalid = CW'(step) < used_count;
  assign fits   = fhead.len >= need;
  assign rest   = fhead.len - need;
  assign last   = (step == LAST);

  // Apply-side decisions
  logic             split, mprev, mnext, fdone;
  logic [LEN_W-1:0] arest, blen;
  logic [START_W:0] prev_end, blk_end;
  assign arest    = sel_len - need;
  assign split    = arest > HDR1;
  assign blen     = split ? need : sel_len;
  assign prev_end = {1'b0, prev_e.start} + (START_W+1)'(prev_e.len);
  assign blk_end  = {1'b0, sel_s} + (START_W+1)'(sel_len);
  assign mprev    = (pos != '0) && (prev_end == {1'b0, sel_s});
  assign mnext    = have_next && (blk_end == {1'b0, next_e.start});
  assign fdone    = mprev || mnext || (free_count < FULL);

  // Broadcast operations to the two rings
  always_comb begin
    fop  = '{code: OP_HOLD, data: '0};
    uop  = '{code: OP_HOLD, data: '0};
    fidx = '0;
    uidx = '0;
    unique case (state)
      ST_INIT: begin
        fop = '{code: OP_WR, data: '{len: LEN_W'(POOL_BYTES), start: '0}};
      end
      ST_FSCAN: fop.code = OP_ROT;
      ST_USCAN: uop.code = OP_ROT;
      ST_APPLY: begin
        if (cmd == CMD_ALLOC) begin
          fidx = hit_idx;
          if (split) begin
            fop = '{code: OP_WR, data: '{len: arest,
                                         start: START_W'(sel_s + START_W'(need))}};
          end else begin
            fop.code = OP_DEL;
          end
          uidx = pos[IW-1:0];
          uop  = '{code: OP_INS, data: '{len: blen, start: sel_s}};
        end else begin
          if (mprev && mnext) begin
            fidx = prev_idx;
            fop  = '{code: OP_WR, data: '{len: LEN_W'(prev_e.len + sel_len + next_e.len),
                                          start: prev_e.start}};
          end else if (mprev) begin
            fidx = prev_idx;
            fop  = '{code: OP_WR, data: '{len: LEN_W'(prev_e.len + sel_len),
                                          start: prev_e.start}};
          end else if (mnext) begin
            fidx = pos[IW-1:0];
            fop  = '{code: OP_WR, data: '{len: LEN_W'(sel_len + next_e.len),
                                          start: sel_s}};
          end else if (fdone) begin
            fidx = pos[IW-1:0];
            fop  = '{code: OP_INS, data: '{len: sel_len, start: sel_s}};
          end
          if (fdone) begin
            uidx     = hit_idx;
            uop.code = OP_DEL;
          end
        end
      end
      ST_APPLY2: begin
        fidx     = pos[IW-1:0];
        fop.code = OP_DEL;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      fit_mode   <= '0;
      free_count <= CW'(1);
      used_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) fit_mode <= cfg_data;
      // Drop valid after the transfer unless a new result loads this cycle
      if (m_tvalid && m_tready && state != ST_RESP) m_tvalid <= 1'b0;

      unique case (state)
        ST_INIT: state <= ST_IDLE;

        ST_IDLE: begin
          if (s_acc) begin
            cmd       <= s_tdata[1:0];
            need      <= (LEN_W'(s_tdata[17:2]) + ROUND) & ~LEN_W'(3);
            tgt       <= s_tdata[33:18] - HDR_S;
            found     <= 1'b0;
            stop      <= 1'b0;
            have_next <= 1'b0;
            pos       <= '0;
            step      <= '0;
            res_ok    <= 1'b0;
            res_addr  <= '0;
            res_usable <= '0;
            unique case (s_tdata[1:0])
              CMD_ALLOC: state <= (used_count == FULL) ? ST_RESP : ST_FSCAN;
              CMD_FREE, CMD_QUERY: begin
                state <= (LEN_W'(s_tdata[33:18]) < HDR) ? ST_RESP : ST_USCAN;
              end
              default: state <= ST_RESP;
            endcase
          end
        end

        ST_FSCAN: begin
          step <= last ? '0 : step + IW'(1);
          if (cmd == CMD_ALLOC) begin
            // Placement: pick a free segment by the fit policy
            if (fvalid && !stop && fits) begin
              if (fit_mode == FIT_BEST) begin
                if (!found || rest < best) begin
                  found <= 1'b1; hit_idx <= step; best <= rest;
                  sel_s <= fhead.start; sel_len <= fhead.len;
                  if (rest == '0) stop <= 1'b1;
                end
              end else if (fit_mode == FIT_WORST) begin
                if (rest == '0 || !found || rest > best) begin
                  found <= 1'b1; hit_idx <= step; best <= rest;
                  sel_s <= fhead.start; sel_len <= fhead.len;
                  if (rest == '0) stop <= 1'b1;
                end
              end else begin
                found <= 1'b1; hit_idx <= step; stop <= 1'b1;
                sel_s <= fhead.start; sel_len <= fhead.len;
              end
            end
            if (last) state <= (found || (fvalid && !stop && fits)) ? ST_USCAN : ST_RESP;
          end else begin
            // Release: locate neighbors around the returned block
            if (fvalid) begin
              if (fhead.start < sel_s) begin
                pos      <= CW'(step) + CW'(1);
                prev_e   <= fhead;
                prev_idx <= step;
              end else if (!have_next) begin
                have_next <= 1'b1;
                next_e    <= fhead;
              end
            end
            if (last) state <= ST_APPLY;
          end
        end

        ST_USCAN: begin
          step <= last ? '0 : step + IW'(1);
          if (cmd == CMD_ALLOC) begin
            if (uvalid && uhead.start < sel_s) pos <= pos + CW'(1);
            if (last) state <= ST_APPLY;
          end else begin
            if (uvalid && !found && uhead.start == tgt) begin
              found   <= 1'b1;
              hit_idx <= step;
              sel_s   <= uhead.start;
              sel_len <= uhead.len;
            end
            if (last) begin
              pos <= '0;
              if (!found && !(uvalid && uhead.start == tgt)) begin
                state <= ST_RESP;
              end else if (cmd == CMD_QUERY) begin
                state <= ST_RESP;
                res_ok <= 1'b1;
                res_usable <= (found ? START_W'(sel_len - HDR1)
                                     : START_W'(uhead.len - HDR1));
              end else begin
                state <= ST_FSCAN;
              end
            end
          end
        end

        ST_APPLY: begin
          state <= ST_RESP;
          if (cmd == CMD_ALLOC) begin
            if (!split) free_count <= free_count - CW'(1);
            used_count <= used_count + CW'(1);
            res_ok     <= 1'b1;
            res_addr   <= sel_s + HDR_S;
            res_usable <= START_W'(blen - HDR1);
          end else begin
            res_ok <= fdone;
            if (fdone) used_count <= used_count - CW'(1);
            if (mprev && mnext) state <= ST_APPLY2;
            else if (!mprev && !mnext && fdone) free_count <= free_count + CW'(1);
          end
        end

        ST_APPLY2: begin
          free_count <= free_count - CW'(1);
          state      <= ST_RESP;
        end

        ST_RESP: begin
          // Hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {(OUT_TDATA_W-33)'(0), res_usable, res_addr, res_ok};
            state    <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  `FLSA_ASSERT_IMP(a_ready_idle, clk, rst, s_tready, state == ST_IDLE, "ready outside idle")
  `FLSA_ASSERT_IMP(a_count_range, clk, rst, 1'b1, (free_count <= FULL) && (used_count <= FULL), "table count overflow")
  `FLSA_ASSERT_NXT(a_accept_busy, clk, rst, s_acc, state != ST_IDLE, "idle after accept")
  `FLSA_ASSERT_NXT(a_merge_resp, clk, rst, state == ST_APPLY2, state == ST_RESP, "merge did not finish")

endmodule

FILE: test/flsa_checker.sv
module flsa_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [flsa_pkg::IN_TDATA_W-1:0]   s_tdata,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [flsa_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [1:0]                        cfg_data,
  output int                                errors,
  output int                                pending
);
  import flsa_pkg::*;

  localparam int unsigned POOL = 65536;
  localparam int unsigned HDR  = 8;
  localparam int unsigned NBLK = 64;

  typedef struct packed {
    logic        ok;
    logic [15:0] addr;
    logic [15:0] usable;
  } alloc_result_t;

  logic [1:0]  fit_mode;
  int unsigned free_start [NBLK];
  int unsigned free_len   [NBLK];
  int unsigned free_cnt;
  int unsigned used_start [NBLK];
  int unsigned used_len   [NBLK];
  int unsigned used_cnt;
  alloc_result_t expected_q[$];

  assign pending = expected_q.size();

  function automatic void remove_free(int unsigned i);
    for (int unsigned k = i; k + 1 < free_cnt; k++) begin
      free_start[k] = free_start[k+1];
      free_len[k]   = free_len[k+1];
    end
    free_cnt--;
  endfunction

  function automatic int choose_segment(int unsigned need);
    int pick;
    int unsigned best;
    int unsigned rest;
    pick = -1;
    best = 0;
    for (int unsigned i = 0; i < free_cnt; i++) begin
      if (free_len[i] < need) continue;
      rest = free_len[i] - need;
      if (fit_mode == FIT_BEST) begin
        if (pick < 0 || rest < best) begin
          pick = int'(i);
          best = rest;
          if (rest == 0) break;
        end
      end else if (fit_mode == FIT_WORST) begin
        // an exact fit beats any remainder
        if (rest == 0) begin
          pick = int'(i);
          break;
        end
        if (pick < 0 || rest > best) begin
          pick = int'(i);
          best = rest;
        end
      end else begin
        return int'(i);
      end
    end
    return pick;
  endfunction

  function automatic alloc_result_t apply_command(logic [1:0] cmd, logic [15:0] req,
                                                  logic [15:0] ua);
    alloc_result_t r;
    int unsigned need, s, len, blen, p;
    int pick, found;
    bit mprev, mnext, done;
    r = '0;
    if (cmd == CMD_ALLOC) begin
      need = (int'(req) + HDR + 4) & ~32'd3;
      pick = choose_segment(need);
      if (pick >= 0 && used_cnt < NBLK) begin
        s   = free_start[pick];
        len = free_len[pick];
        // split only when the leftover is larger than a header and a guard byte
        if (len - need > HDR + 1) begin
          blen = need;
          free_start[pick] = (s + need) & 32'hFFFF;
          free_len[pick]   = len - need;
        end else begin
          blen = len;
          remove_free(pick);
        end
        p = 0;
        while (p < used_cnt && used_start[p] < s) p++;
        for (int unsigned k = used_cnt; k > p; k--) begin
          used_start[k] = used_start[k-1];
          used_len[k]   = used_len[k-1];
        end
        used_start[p] = s;
        used_len[p]   = blen;
        used_cnt++;
        r.ok     = 1'b1;
        r.addr   = 16'(s + HDR);
        r.usable = 16'(blen - HDR - 1);
      end
    end else if (cmd == CMD_FREE || cmd == CMD_QUERY) begin
      found = -1;
      if (ua >= HDR) begin
        for (int unsigned j = 0; j < used_cnt; j++)
          if (used_start[j] == ua - HDR) begin
            found = int'(j);
            break;
          end
      end
      if (found >= 0 && cmd == CMD_QUERY) begin
        r.ok     = 1'b1;
        r.usable = 16'(used_len[found] - HDR - 1);
      end else if (found >= 0) begin
        s    = used_start[found];
        len  = used_len[found];
        done = 1'b1;
        p    = 0;
        while (p < free_cnt && free_start[p] < s) p++;
        mprev = p > 0 && free_start[p-1] + free_len[p-1] == s;
        mnext = p < free_cnt && s + len == free_start[p];
        if (mprev && mnext) begin
          free_len[p-1] += len + free_len[p];
          remove_free(p);
        end else if (mprev) begin
          free_len[p-1] += len;
        end else if (mnext) begin
          free_start[p] = s;
          free_len[p]   += len;
        end else if (free_cnt < NBLK) begin
          for (int unsigned k = free_cnt; k > p; k--) begin
            free_start[k] = free_start[k-1];
            free_len[k]   = free_len[k-1];
          end
          free_start[p] = s;
          free_len[p]   = len;
          free_cnt++;
        end else begin
          // free table full: the block stays allocated
          done = 1'b0;
        end
        if (done) begin
          for (int unsigned k = found; k + 1 < used_cnt; k++) begin
            used_start[k] = used_start[k+1];
            used_len[k]   = used_len[k+1];
          end
          used_cnt--;
          r.ok = 1'b1;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t got, want;
    if (rst) begin
      fit_mode      = FIT_FIRST;
      free_start[0] = 0;
      free_len[0]   = POOL;
      free_cnt      = 1;
      used_cnt      = 0;
      errors        = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) fit_mode = cfg_data;
      // compare the transfer leaving the block before predicting the one entering
      if (m_tvalid && m_tready) begin
        got = '{ok: m_tdata[0], addr: m_tdata[16:1], usable: m_tdata[32:17]};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result ok=%0d addr=%0d usable=%0d", $time,
                   got.ok, got.addr, got.usable);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.ok !== want.ok) begin
            $display("%0t: ok expected %0d actual %0d", $time, want.ok, got.ok);
            errors++;
          end
          if (got.addr !== want.addr) begin
            $display("%0t: out_addr expected %0d actual %0d", $time, want.addr, got.addr);
            errors++;
          end
          if (got.usable !== want.usable) begin
            $display("%0t: usable_bytes expected %0d actual %0d", $time, want.usable,
                     got.usable);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_q.push_back(apply_command(s_tdata[1:0], s_tdata[17:2], s_tdata[33:18]));
    end
  end

endmodule

FILE: test/tb_free_list_segment_allocator.sv
module tb_free_list_segment_allocator;
  import flsa_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 600;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // [1:0] cmd, [17:2] req_bytes, [33:18] user_addr
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // [0] ok, [16:1] out_addr, [32:17] usable_bytes
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [1:0]             cfg_data;
  int                     errors;
  int                     pending;

  // stimulus knobs shared between the sender and the receiver
  bit                     quiet;
  bit                     hold_req;
  logic [1:0]             issued_cmds[$];
  logic [15:0]            live_addrs[$];

  free_list_segment_allocator u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  flsa_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one; none at all in quiet phases.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    int g;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        g = pick_gap();
        if (g > 0) begin
          m_tready <= 1'b0;
          repeat (g) @(posedge clk);
        end
        m_tready <= 1'b1;
      end
    end
  end

  // Learn the user addresses handed out, so frees and queries hit live blocks.
  always @(posedge clk) begin
    logic [1:0] c;
    if (!rst) begin
      if (m_tvalid && m_tready && issued_cmds.size() > 0) begin
        c = issued_cmds.pop_front();
        if (c == CMD_ALLOC && m_tdata[0]) live_addrs.push_back(m_tdata[16:1]);
      end
      if (s_tvalid && s_tready) issued_cmds.push_back(s_tdata[1:0]);
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("%0t: watchdog timeout, %0d results outstanding", $time, pending);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Offer one item, hold it until the transfer, then idle for a random gap.
  task automatic send_cmd(logic [1:0] cmd, logic [15:0] req, logic [15:0] ua);
    int g;
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, ua, req, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    g = pick_gap();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every result has drained.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_fit_mode(logic [1:0] mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_req();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(0, 300));
    if (r < 92) return 16'($urandom_range(0, 3000));
    if (r < 98) return 16'($urandom_range(0, 65535));
    return (r == 98) ? 16'hFFFF : 16'h0000;
  endfunction

  function automatic logic [15:0] pick_addr(bit take);
    int idx;
    if (live_addrs.size() == 0 || $urandom_range(0, 9) == 0)
      return ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 16))
                                         : 16'($urandom_range(0, 65535));
    idx = $urandom_range(0, live_addrs.size() - 1);
    pick_addr = live_addrs[idx];
    if (take) live_addrs.delete(idx);
  endfunction

  task automatic random_items(int count, int alloc_pct, bit with_hold);
    int r;
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == count / 3) hold_req = 1'b1;
      r = $urandom_range(0, 99);
      if (r < alloc_pct)
        send_cmd(CMD_ALLOC, pick_req(), 16'($urandom_range(0, 65535)));
      else if (r < alloc_pct + (100 - alloc_pct) * 6 / 10)
        send_cmd(CMD_FREE, 16'($urandom_range(0, 65535)), pick_addr(1'b1));
      else if (r < 95)
        send_cmd(CMD_QUERY, 16'($urandom_range(0, 65535)), pick_addr(1'b0));
      else
        send_cmd(CMD_RSVD, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    end
  endtask

  initial begin
    logic [1:0] modes[7];
    int alloc_pcts[7];
    modes      = '{FIT_FIRST, FIT_BEST, FIT_WORST, FIT_RSVD, FIT_BEST, FIT_WORST, FIT_FIRST};
    alloc_pcts = '{55, 80, 50, 85, 45, 80, 60};
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_data  = FIT_FIRST;
    quiet     = 1'b0;
    hold_req  = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: whole pool, no fit, unknown blocks, no-split, merges.
    write_fit_mode(FIT_FIRST);
    send_cmd(CMD_ALLOC, 16'd65524, 16'd0);       // takes the whole pool exactly
    send_cmd(CMD_ALLOC, 16'd0, 16'd0);           // nothing left
    send_cmd(CMD_QUERY, 16'd0, 16'd8);
    send_cmd(CMD_FREE, 16'd0, 16'd8);
    send_cmd(CMD_FREE, 16'd0, 16'd8);            // already freed
    send_cmd(CMD_FREE, 16'd0, 16'd0);            // below the header size
    send_cmd(CMD_QUERY, 16'hFFFF, 16'hFFFF);
    send_cmd(CMD_RSVD, 16'hFFFF, 16'hFFFF);      // unknown command
    send_cmd(CMD_ALLOC, 16'hFFFF, 16'd0);        // larger than the pool
    send_cmd(CMD_ALLOC, 16'd65516, 16'd0);       // remainder too small to split
    send_cmd(CMD_QUERY, 16'd0, 16'd8);
    send_cmd(CMD_FREE, 16'd0, 16'd8);
    send_cmd(CMD_ALLOC, 16'd0, 16'd0);           // ua 8
    send_cmd(CMD_ALLOC, 16'd4, 16'd0);           // ua 20
    send_cmd(CMD_ALLOC, 16'd3, 16'd0);           // ua 36
    send_cmd(CMD_ALLOC, 16'd100, 16'd0);         // ua 48
    send_cmd(CMD_FREE, 16'd0, 16'd8);            // no neighbor free
    send_cmd(CMD_FREE, 16'd0, 16'd36);
    send_cmd(CMD_FREE, 16'd0, 16'd20);           // merges on both sides
    send_cmd(CMD_FREE, 16'd0, 16'd48);           // merges on both sides, back into the whole pool
    send_cmd(CMD_QUERY, 16'd0, 16'd48);
    drain();
    live_addrs.delete();

    // Random phases, one fit mode each; the sender pauses for a full drain between.
    for (int ph = 0; ph < 7; ph++) begin
      write_fit_mode(modes[ph]);
      quiet = (ph == 2 || ph == 5);
      random_items(75, alloc_pcts[ph], ph == 1 || ph == 4);
      drain();
    end

    // settle: let any stray result show up
    repeat (300) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
